// ===== hw/rtl/ioq_pkg.sv =====
// shared types, constants and helper functions for the issue queue select block
// no dependencies; every other file refers to it by scoped names
`timescale 1ns / 1ps

package ioq_pkg;

    localparam int SLOT_W      = 8;
    localparam int CAP_PER_WAY = 5;

    localparam logic [2:0] LAT_ALU = 3'd1;
    localparam logic [2:0] LAT_MUL = 3'd2;
    localparam logic [2:0] LAT_DIV = 3'd5;
    localparam logic [1:0] OP_MUL  = 2'd1;
    localparam logic [1:0] OP_DIV  = 2'd2;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_WAKE   = 2'd1,
        CMD_ISSUE  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        B_IDLE,
        B_STAMP,
        B_PASS,
        B_FLUSH
    } t_bstate;

    typedef struct packed {
        t_kind        kind;
        logic [5:0]   slot;
        logic [31:0]  age;
        logic [1:0]   op;
        logic         p1;
        logic         p2;
        logic [31:0]  now;
        logic [5:0]   occ;
    } t_cmd;

    typedef struct packed {
        logic              vld;
        logic [31:0]       age;
        logic [SLOT_W-1:0] slot;
        logic [1:0]        op;
        logic [31:0]       seen;
    } t_node;

    typedef struct packed {
        logic        issued;
        logic [5:0]  slot;
        logic [31:0] age;
        logic [2:0]  lat;
        logic [31:0] qwait;
        logic        last;
    } t_res;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [2:0] lat_of(input logic [1:0] op);
        logic [2:0] l;
        l = LAT_ALU;
        if (op == OP_MUL) l = LAT_MUL;
        if (op == OP_DIV) l = LAT_DIV;
        return l;
    endfunction

    // lower half holds lower slots, so it wins ties
    function automatic t_node pick(input t_node a, input t_node b);
        t_node r;
        r = a;
        if (b.vld && (!a.vld || (b.age < a.age))) r = b;
        return r;
    endfunction

endpackage

// ===== hw/rtl/ioq_front.sv =====
// front end: decodes an incoming transaction into a queue command
// depends on ioq_pkg
`timescale 1ns / 1ps

module ioq_front #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic           i_tvalid,
    output logic           o_tready,
    input  logic [1:0]     i_tuser,
    input  logic [79:0]    i_tdata,
    input  ioq_pkg::t_qstat i_qstat,
    output logic           o_push,
    output ioq_pkg::t_cmd  o_cmd
);

    logic w_keep;

    assign o_tready = !i_qstat.full;

    always_comb begin
        o_cmd.kind = ioq_pkg::t_kind'(i_tuser);
        o_cmd.slot = i_tdata[5:0];
        o_cmd.age  = i_tdata[37:6];
        o_cmd.op   = i_tdata[39:38];
        o_cmd.p1   = i_tdata[40];
        o_cmd.p2   = i_tdata[41];
        o_cmd.now  = i_tdata[73:42];
        o_cmd.occ  = i_tdata[79:74];
        case (ioq_pkg::t_kind'(i_tuser))
            ioq_pkg::CMD_INSERT, ioq_pkg::CMD_WAKE: begin
                w_keep = 32'(i_tdata[5:0]) < QUEUE_DEPTH;
            end
            ioq_pkg::CMD_ISSUE: begin
                w_keep = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    // dropped transactions are still accepted
    assign o_push = i_tvalid && o_tready && w_keep;

endmodule

// ===== hw/rtl/ioq_fifo.sv =====
// short command queue between the front end and the select engine
// depends on ioq_pkg
`timescale 1ns / 1ps

module ioq_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ioq_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output ioq_pkg::t_cmd   o_cmd,
    output ioq_pkg::t_qstat o_qstat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ioq_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_qstat.full  = r_cnt == CW'(DEPTH);
    assign o_qstat.empty = r_cnt == '0;
    assign o_cmd         = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

endmodule

// ===== hw/rtl/ioq_back.sv =====
// select engine: entry storage, registered oldest-ready tree and result register
// depends on ioq_pkg
`timescale 1ns / 1ps

module ioq_back #(
    parameter int QUEUE_DEPTH = 64,
    parameter int MAX_WIDTH   = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [3:0]      i_issue_width,
    input  ioq_pkg::t_cmd   i_cmd,
    input  ioq_pkg::t_qstat i_qstat,
    output logic            o_pop,
    output logic            o_tvalid,
    input  logic            i_tready,
    output ioq_pkg::t_res   o_res
);

    localparam int LV  = $clog2(QUEUE_DEPTH);
    localparam int N2  = 1 << LV;
    localparam int SIW = LV;
    localparam int STG = LV / 2;
    localparam int CW  = $clog2(STG + 2);

    ioq_pkg::t_bstate r_state, n_state;

    logic [QUEUE_DEPTH-1:0] r_valid, r_seen;
    logic [31:0] r_age   [QUEUE_DEPTH];
    logic [1:0]  r_op    [QUEUE_DEPTH];
    logic [1:0]  r_pend  [QUEUE_DEPTH];
    logic [31:0] r_first [QUEUE_DEPTH];

    ioq_pkg::t_cmd r_cur;
    logic [4:0]    r_w, r_pass;
    logic [CW-1:0] r_cnt;
    logic          r_has, r_ovld;
    ioq_pkg::t_res r_hold, r_odata;

    ioq_pkg::t_node w_lvl [LV+1][N2];
    ioq_pkg::t_node w_win;

    logic [4:0] w_w;
    logic [7:0] w_cap;
    logic       w_can_emit, w_settled;
    logic       w_sel, w_end, w_flush, w_emit;
    logic       w_new_full, w_start_full;

    // leaves of the select tree
    genvar j, l, k;
    for (j = 0; j < N2; j++) begin : g_leaf
        if (j < QUEUE_DEPTH) begin : g_real
            assign w_lvl[0][j].vld  = r_valid[j] && (r_pend[j] == 2'b00);
            assign w_lvl[0][j].age  = r_age[j];
            assign w_lvl[0][j].slot = ioq_pkg::SLOT_W'(j);
            assign w_lvl[0][j].op   = r_op[j];
            assign w_lvl[0][j].seen = r_first[j];
        end else begin : g_pad
            assign w_lvl[0][j] = '0;
        end
    end

    // a register every second level of the tree
    for (l = 1; l <= LV; l++) begin : g_lvl
        for (k = 0; k < (N2 >> l); k++) begin : g_node
            if (l % 2 == 0) begin : g_reg
                always_ff @(posedge i_clk) begin
                    w_lvl[l][k] <= ioq_pkg::pick(w_lvl[l-1][2*k], w_lvl[l-1][2*k+1]);
                end
            end else begin : g_cmb
                assign w_lvl[l][k] = ioq_pkg::pick(w_lvl[l-1][2*k], w_lvl[l-1][2*k+1]);
            end
        end
    end

    assign w_win = w_lvl[LV][0];

    assign w_w   = (5'(i_issue_width) > 5'(MAX_WIDTH)) ? 5'(MAX_WIDTH) : 5'(i_issue_width);
    assign w_cap = 8'(r_w) * 8'(ioq_pkg::CAP_PER_WAY);

    assign w_can_emit   = !r_ovld || i_tready;
    assign w_settled    = r_cnt == CW'(STG);
    assign w_start_full = (8'(w_w) == 8'd0) ||
                          (8'(i_cmd.occ) >= 8'(w_w) * 8'(ioq_pkg::CAP_PER_WAY));
    assign w_new_full   = (r_pass + 5'd1 == r_w) ||
                          (8'(r_cur.occ) + 8'(r_pass) + 8'd1 >= w_cap);

    // outputs of the sequencer
    always_comb begin
        o_pop   = (r_state == ioq_pkg::B_IDLE) && !i_qstat.empty;
        w_sel   = (r_state == ioq_pkg::B_PASS) && w_settled && w_win.vld &&
                  (!r_has || w_can_emit);
        w_end   = (r_state == ioq_pkg::B_PASS) && w_settled && !w_win.vld && w_can_emit;
        w_flush = (r_state == ioq_pkg::B_FLUSH) && w_can_emit;
        w_emit  = (w_sel && r_has) || w_end || w_flush;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ioq_pkg::B_IDLE: begin
                if (o_pop && i_cmd.kind == ioq_pkg::CMD_ISSUE) begin
                    n_state = w_start_full ? ioq_pkg::B_FLUSH : ioq_pkg::B_STAMP;
                end
            end
            ioq_pkg::B_STAMP: begin
                n_state = ioq_pkg::B_PASS;
            end
            ioq_pkg::B_PASS: begin
                if (w_sel && w_new_full) begin
                    n_state = ioq_pkg::B_FLUSH;
                end else if (w_end) begin
                    n_state = ioq_pkg::B_IDLE;
                end
            end
            ioq_pkg::B_FLUSH: begin
                if (w_flush) n_state = ioq_pkg::B_IDLE;
            end
            default: begin
                n_state = ioq_pkg::B_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ioq_pkg::B_IDLE;
            r_valid <= '0;
            r_seen  <= '0;
            r_ovld  <= 1'b0;
            r_has   <= 1'b0;
            r_cnt   <= '0;
            r_pass  <= '0;
            r_w     <= '0;
        end else begin
            r_state <= n_state;
            if (w_emit) r_ovld <= 1'b1;
            else if (r_ovld && i_tready) r_ovld <= 1'b0;
            if (o_pop) begin
                case (i_cmd.kind)
                    ioq_pkg::CMD_INSERT: begin
                        r_valid[SIW'(i_cmd.slot)] <= 1'b1;
                        r_seen[SIW'(i_cmd.slot)]  <= 1'b0;
                    end
                    ioq_pkg::CMD_ISSUE: begin
                        r_w    <= w_w;
                        r_pass <= '0;
                        r_has  <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == ioq_pkg::B_STAMP) begin
                r_seen <= r_seen | r_valid;
                r_cnt  <= '0;
            end
            if (r_state == ioq_pkg::B_PASS && !w_settled) r_cnt <= r_cnt + 1'b1;
            if (w_sel) begin
                r_valid[w_win.slot[SIW-1:0]] <= 1'b0;
                r_has  <= 1'b1;
                r_pass <= r_pass + 5'd1;
                r_cnt  <= '0;
            end
            if (w_end || w_flush) r_has <= 1'b0;
        end
    end

    // entry payload and result data
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            case (i_cmd.kind)
                ioq_pkg::CMD_INSERT: begin
                    r_age[SIW'(i_cmd.slot)]  <= i_cmd.age;
                    r_op[SIW'(i_cmd.slot)]   <= i_cmd.op;
                    r_pend[SIW'(i_cmd.slot)] <= {i_cmd.p2, i_cmd.p1};
                end
                ioq_pkg::CMD_WAKE: begin
                    if (i_cmd.p2) r_pend[SIW'(i_cmd.slot)][1] <= 1'b0;
                    else          r_pend[SIW'(i_cmd.slot)][0] <= 1'b0;
                end
                ioq_pkg::CMD_ISSUE: begin
                    r_cur <= i_cmd;
                end
                default: begin
                end
            endcase
        end
        if (r_state == ioq_pkg::B_STAMP) begin
            for (int e = 0; e < QUEUE_DEPTH; e++) begin
                if (r_valid[e] && !r_seen[e]) r_first[e] <= r_cur.now;
            end
        end
        if (w_sel) begin
            r_hold.issued <= 1'b1;
            r_hold.slot   <= w_win.slot[5:0];
            r_hold.age    <= w_win.age;
            r_hold.lat    <= ioq_pkg::lat_of(w_win.op);
            r_hold.qwait  <= r_cur.now - w_win.seen + 32'd1;
            r_hold.last   <= 1'b0;
        end
        if (w_emit) begin
            if (r_has) begin
                r_odata.issued <= r_hold.issued;
                r_odata.slot   <= r_hold.slot;
                r_odata.age    <= r_hold.age;
                r_odata.lat    <= r_hold.lat;
                r_odata.qwait  <= r_hold.qwait;
                r_odata.last   <= w_end || w_flush;
            end else begin
                r_odata.issued <= 1'b0;
                r_odata.slot   <= '0;
                r_odata.age    <= '0;
                r_odata.lat    <= '0;
                r_odata.qwait  <= '0;
                r_odata.last   <= 1'b1;
            end
        end
    end

    assign o_tvalid = r_ovld;
    assign o_res    = r_odata;

endmodule

// ===== hw/rtl/issue_queue_oldest_ready_select.sv =====
// issue queue with oldest-ready-first select; each select pass waits for the registered tree
// to settle after each freed slot. an issue transaction grants entries until width or execute
// room runs out or no ready entry is left; with a full execute stage it grants nothing, skips
// the select passes and sends one empty last result. reset empties the queue, issue_width is 4.
`timescale 1ns / 1ps

module issue_queue_oldest_ready_select #(
    parameter int QUEUE_DEPTH = 64,
    parameter int MAX_WIDTH   = 8,
    parameter int FIFO_DEPTH  = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,  // action
    // slot, age, op_kind, first_src_pending, second_src_pending, cycle_now, exec_occupancy
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic        m_axis_tuser,  // issued
    // issued_slot, issued_age, exec_latency, queue_wait, zero fill
    output logic [79:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    logic [3:0]      r_issue_width;
    logic            w_push, w_pop;
    ioq_pkg::t_cmd   w_in_cmd, w_q_cmd;
    ioq_pkg::t_qstat w_qstat;
    ioq_pkg::t_res   w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_width <= 4'd4;
        end else if (i_cfg_wr_en) begin
            r_issue_width <= i_cfg_wr_data;
        end
    end

    ioq_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tuser  (s_axis_tuser),
        .i_tdata  (s_axis_tdata),
        .i_qstat  (w_qstat),
        .o_push   (w_push),
        .o_cmd    (w_in_cmd)
    );

    ioq_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_in_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd),
        .o_qstat (w_qstat)
    );

    ioq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_issue_width (r_issue_width),
        .i_cmd         (w_q_cmd),
        .i_qstat       (w_qstat),
        .o_pop         (w_pop),
        .o_tvalid      (m_axis_tvalid),
        .i_tready      (m_axis_tready),
        .o_res         (w_res)
    );

    assign m_axis_tuser = w_res.issued;
    assign m_axis_tlast = w_res.last;
    assign m_axis_tdata = {7'd0, w_res.qwait, w_res.lat, w_res.age, w_res.slot};

    // an empty issue result always closes its transaction
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("empty result without last");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("command queue overflow");

    // an issued instruction carries a non-zero latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[40:38] != 3'd0)
        else $error("issued result with zero latency");

endmodule

// ===== bench/tb_issue_queue_oldest_ready_select.sv =====
// testbench for the oldest-ready-first issue queue select block
// depends on ioq_pkg (command and op codes) and issue_queue_oldest_ready_select
`timescale 1ns / 1ps

module tb_issue_queue_oldest_ready_select;

    localparam int DEPTH      = 64;
    localparam int WIDTH_MAX  = 8;
    localparam int STALL_LIM  = 20000;
    localparam int HOLD_LEN   = 400;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic        issued;
        logic [5:0]  slot;
        logic [31:0] age;
        logic [2:0]  lat;
        logic [31:0] qwait;
        logic        last;
    } t_grant;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [3:0]  i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser;   // action
    // slot, age, op_kind, first_src_pending, second_src_pending, cycle_now, exec_occupancy
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic        m_axis_tuser;   // issued
    // issued_slot, issued_age, exec_latency, queue_wait, zero fill
    logic [79:0] m_axis_tdata;
    logic        m_axis_tlast;

    // predictor state
    logic [3:0]  width_reg;
    logic        q_valid [DEPTH];
    logic [31:0] q_age   [DEPTH];
    logic [1:0]  q_op    [DEPTH];
    logic [1:0]  q_pend  [DEPTH];
    logic [31:0] q_seen  [DEPTH];
    logic        q_stamped [DEPTH];

    t_grant      grants_due[$];
    int          mismatches = 0;
    int          grants_seen = 0;
    int          idle_cycles = 0;
    logic        timed_out = 1'b0;
    logic        rx_gaps;
    logic        tx_gaps;
    logic        hold_req = 1'b0;
    logic        hold_taken = 1'b0;
    int          hold_off = 0;
    logic [31:0] cycle_ctr;

    issue_queue_oldest_ready_select i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [2:0] latency_for(input logic [1:0] op);
        case (op)
            ioq_pkg::OP_MUL: return 3'd2;
            ioq_pkg::OP_DIV: return 3'd5;
            default:         return 3'd1;
        endcase
    endfunction

    function automatic void append_grant(input t_grant g);
        grants_due = {grants_due, g};
    endfunction

    task automatic predict_grants(input logic [1:0] cmd, input logic [5:0] slot,
                                  input logic [31:0] age, input logic [1:0] op,
                                  input logic p1, input logic p2,
                                  input logic [31:0] now, input logic [5:0] occ);
        int     w;
        int     n;
        int     best;
        t_grant g;
        if (cmd == ioq_pkg::CMD_INSERT) begin
            q_valid[slot]   = 1'b1;
            q_age[slot]     = age;
            q_op[slot]      = op;
            q_pend[slot]    = {p2, p1};
            q_stamped[slot] = 1'b0;
            q_seen[slot]    = '0;
        end else if (cmd == ioq_pkg::CMD_WAKE) begin
            q_pend[slot] = q_pend[slot] & (p2 ? 2'b01 : 2'b10);
        end else if (cmd == ioq_pkg::CMD_ISSUE) begin
            w = (width_reg > WIDTH_MAX) ? WIDTH_MAX : int'(width_reg);
            n = 0;
            for (int p = 0; p < w; p++) begin
                if (int'(occ) + n >= w * 5) break;
                best = -1;
                for (int j = 0; j < DEPTH; j++) begin
                    if (!q_valid[j]) continue;
                    if (!q_stamped[j]) begin
                        q_stamped[j] = 1'b1;
                        q_seen[j]    = now;
                    end
                    if (q_pend[j] != 2'b00) continue;
                    if (best < 0 || q_age[j] < q_age[best]) best = j;
                end
                if (best < 0) break;
                g.issued = 1'b1;
                g.slot   = best[5:0];
                g.age    = q_age[best];
                g.lat    = latency_for(q_op[best]);
                g.qwait  = now - q_seen[best] + 32'd1;
                g.last   = 1'b0;
                q_valid[best] = 1'b0;
                append_grant(g);
                n++;
            end
            if (n == 0) begin
                g = '0;
                g.last = 1'b1;
                append_grant(g);
            end else begin
                grants_due[grants_due.size() - 1].last = 1'b1;
            end
        end
    endtask

    // one transaction into the queue; gaps before it when enabled
    task automatic send_cmd(input logic [1:0] cmd, input logic [5:0] slot,
                            input logic [31:0] age, input logic [1:0] op,
                            input logic p1, input logic p2,
                            input logic [31:0] now, input logic [5:0] occ);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {occ, now, p2, p1, op, age, slot};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_grants(cmd, slot, age, op, p1, p2, now, occ);
    endtask

    task automatic go_quiet();
        s_axis_tvalid <= 1'b0;
        while (grants_due.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_width(input logic [3:0] w);
        go_quiet();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        width_reg = w;
    endtask

    task automatic issue_now(input logic [5:0] occ);
        send_cmd(ioq_pkg::CMD_ISSUE, 6'($urandom), $urandom, 2'($urandom), 1'($urandom),
                 1'($urandom), cycle_ctr, occ);
        cycle_ctr = cycle_ctr + $urandom_range(1, 5);
    endtask

    task automatic test_directed();
        send_cmd(ioq_pkg::CMD_INSERT, 6'd0, 32'hFFFF_FFFF, 2'd0, 1'b0, 1'b0, 0, 0);
        send_cmd(ioq_pkg::CMD_INSERT, 6'd63, 32'd0, 2'd3, 1'b1, 1'b1, 0, 0);
        send_cmd(ioq_pkg::CMD_INSERT, 6'd5, 32'd7, 2'd1, 1'b0, 1'b0, 0, 0);
        send_cmd(ioq_pkg::CMD_INSERT, 6'd9, 32'd7, 2'd2, 1'b0, 1'b0, 0, 0);
        // full execute stage, then beyond capacity: no grant, stamps untouched; then room for two grants
        send_cmd(ioq_pkg::CMD_ISSUE, 0, 0, 0, 0, 0, 32'hFFFF_FFF0, 6'd20);
        send_cmd(ioq_pkg::CMD_ISSUE, 0, 0, 0, 0, 0, 32'hFFFF_FFF1, 6'd40);
        send_cmd(ioq_pkg::CMD_ISSUE, 0, 0, 0, 0, 0, 32'hFFFF_FFFE, 6'd18);
        send_cmd(ioq_pkg::CMD_WAKE, 6'd63, 0, 0, 0, 1'b0, 0, 0);
        send_cmd(ioq_pkg::CMD_WAKE, 6'd63, 0, 0, 0, 1'b1, 0, 0);
        send_cmd(ioq_pkg::CMD_WAKE, 6'd30, 0, 0, 0, 1'b1, 0, 0);
        send_cmd(CMD_SPARE, 6'd1, 32'hDEAD_BEEF, 2'd3, 1'b1, 1'b1, 32'hFFFF_FFFF, 6'd63);
        // counter wraps: wait crosses zero
        send_cmd(ioq_pkg::CMD_ISSUE, 0, 0, 0, 0, 0, 32'd2, 6'd0);
        send_cmd(ioq_pkg::CMD_INSERT, 6'd5, 32'd3, 2'd2, 1'b0, 1'b0, 0, 0);
        send_cmd(ioq_pkg::CMD_INSERT, 6'd5, 32'd4, 2'd0, 1'b0, 1'b1, 0, 0);
        send_cmd(ioq_pkg::CMD_ISSUE, 0, 0, 0, 0, 0, 32'd10, 6'd0);
        send_cmd(ioq_pkg::CMD_WAKE, 6'd5, 0, 0, 0, 1'b1, 0, 0);
        send_cmd(ioq_pkg::CMD_ISSUE, 0, 0, 0, 0, 0, 32'd15, 6'd0);
        send_cmd(ioq_pkg::CMD_ISSUE, 0, 0, 0, 0, 0, 32'd16, 6'd0);
    endtask

    task automatic test_widths();
        logic [3:0] wl [4] = '{4'd0, 4'd15, 4'd1, 4'd8};
        foreach (wl[k]) begin
            set_width(wl[k]);
            for (int i = 0; i < 10; i++)
                send_cmd(ioq_pkg::CMD_INSERT, 6'($urandom), $urandom_range(0, 40),
                         2'($urandom), 1'b0, 1'b0, 0, 0);
            issue_now(6'($urandom_range(0, 3)));
            issue_now(6'd0);
        end
    endtask

    // random stream: inserts, wakeups of random slots, spare commands and random issues
    task automatic test_random(input int count);
        logic [5:0] s;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_cmd(ioq_pkg::CMD_INSERT, 6'($urandom), $urandom,
                                     2'($urandom), 1'($urandom), 1'($urandom), $urandom,
                                     6'($urandom));
                4, 5: begin
                    s = 6'($urandom);
                    send_cmd(ioq_pkg::CMD_WAKE, s, $urandom, 2'($urandom), 1'($urandom),
                             1'($urandom), $urandom, 6'($urandom));
                end
                6: send_cmd(CMD_SPARE, 6'($urandom), $urandom, 2'($urandom), 1'($urandom),
                            1'($urandom), $urandom, 6'($urandom));
                default: issue_now(6'($urandom_range(0, 100) < 80 ?
                                      $urandom_range(0, 10) : $urandom_range(0, 63)));
            endcase
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) begin
            send_cmd(ioq_pkg::CMD_INSERT, 6'($urandom), $urandom, 2'($urandom),
                     1'b0, 1'b0, 0, 0);
            issue_now(6'd0);
        end
    endtask

    // receiver: random stalls, one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken    <= 1'b1;
            hold_off      <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off      <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_cycles > 0) begin
            idle_cycles   <= idle_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
            idle_cycles   <= $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_grant got;
        t_grant want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.issued = m_axis_tuser;
            got.slot   = m_axis_tdata[5:0];
            got.age    = m_axis_tdata[37:6];
            got.lat    = m_axis_tdata[40:38];
            got.qwait  = m_axis_tdata[72:41];
            got.last   = m_axis_tlast;
            grants_seen++;
            if (grants_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected grant: %p", got);
            end else begin
                want = grants_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("grant mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    int quiet_ctr = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_ctr <= 0;
        else
            quiet_ctr <= quiet_ctr + 1;
        if (quiet_ctr >= STALL_LIM && !timed_out) begin
            timed_out = 1'b1;
            $display("tb_issue_queue_oldest_ready_select: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = '0;
        s_axis_tdata  = '0;
        rx_gaps       = 1'b0;
        tx_gaps       = 1'b0;
        cycle_ctr     = 32'd100;
        width_reg     = 4'd4;
        for (int j = 0; j < DEPTH; j++) begin
            q_valid[j] = 1'b0;
            q_stamped[j] = 1'b0;
            q_age[j] = '0;
            q_op[j] = '0;
            q_pend[j] = '0;
            q_seen[j] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        rx_gaps = 1'b1;
        tx_gaps = 1'b1;
        test_widths();
        set_width(4'd3);
        test_random(90);
        set_width(4'd6);
        test_backpressure();
        test_random(100);
        rx_gaps = 1'b0;
        tx_gaps = 1'b0;
        test_random(40);
        go_quiet();

        $display("covered widths 0, 1, 3, 6, 8 and 15, full execute stage, wakeups,");
        $display("tie breaks and a long output stall; %0d grants checked", grants_seen);
        if (mismatches == 0 && grants_due.size() == 0)
            $display("tb_issue_queue_oldest_ready_select: clean");
        else
            $display("tb_issue_queue_oldest_ready_select: errors");
        $finish;
    end

endmodule
